FILE: src/zero_run_word_codec_assert.svh
// Assertion macros for the zero-run word codec.
// Expects clk and rst_n in the scope of each use.
`ifndef ZERO_RUN_WORD_CODEC_ASSERT_SVH
`define ZERO_RUN_WORD_CODEC_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define ZRWC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ZRWC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/zrwc_pkg.sv
// Shared types and constants for the zero-run word codec.
// No dependencies.
`timescale 1ns / 1ps

package zrwc_pkg;

  localparam int MAX_WORDS   = 64;
  localparam int WORD_BITS   = 32;
  localparam int LEN_W       = $clog2(MAX_WORDS + 1);
  localparam int IDX_W       = $clog2(MAX_WORDS);
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int SLOTS       = 5;
  localparam int REG_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int STATUS_W    = 2;
  // Extra zeros of a positive 16-bit signed count token
  localparam int EXTRA_W     = 15;

  // Register indexes (byte address / 4)
  localparam logic REG_DIRECTION    = 1'b0;
  localparam logic REG_VECTOR_WORDS = 1'b1;

  // Direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERRUN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_END = 2'd2;

  // Encode token slots, in emission order
  localparam int SLOT_PRE_COUNT = 0;
  localparam int SLOT_WORD      = 1;
  localparam int SLOT_RUN_COUNT = 2;
  localparam int SLOT_END_WORD  = 3;
  localparam int SLOT_END_COUNT = 4;

  typedef struct packed {
    logic             direction;
    logic [LEN_W-1:0] eff_len;
    logic             clear;
  } cfg_t;

  // One unit of work for the back end: either a set of encode token slots
  // or a decode run of words with consecutive indexes.
  typedef struct packed {
    logic                 is_run;
    logic [WORD_BITS-1:0] value;
    logic [LEN_W-1:0]     pre_count;
    logic [LEN_W-1:0]     run_count;
    logic [SLOTS-1:0]     mask;
    logic [IDX_W-1:0]     start;
    logic [LEN_W-1:0]     len;
    logic                 done;
    logic [STATUS_W-1:0]  status;
  } job_t;

endpackage

FILE: src/zrwc_if.sv
// Word channel interfaces for the zero-run word codec.
// Depends on zrwc_pkg.
`timescale 1ns / 1ps

interface zrwc_in_if;
  logic                           valid;
  logic                           ready;
  logic [zrwc_pkg::WORD_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface zrwc_out_if;
  logic                           valid;
  logic                           ready;
  logic [zrwc_pkg::WORD_BITS-1:0] value;
  logic                           is_count;
  logic [zrwc_pkg::IDX_W-1:0]     word_index;
  logic                           done_res;
  logic [zrwc_pkg::STATUS_W-1:0]  status;
  logic                           last;

  modport source (output valid, output value, output is_count, output word_index,
                  output done_res, output status, output last, input ready);
  modport sink   (input valid, input value, input is_count, input word_index,
                  input done_res, input status, input last, output ready);
endinterface

FILE: src/zrwc_front.sv
// Front end: accepts input words, tracks vector state, emits jobs.
// Depends on zrwc_pkg, zrwc_if and the assertion header.
`timescale 1ns / 1ps
`include "zero_run_word_codec_assert.svh"

module zrwc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  zrwc_pkg::cfg_t      cfg,
  zrwc_in_if.sink             in_ch,
  input  logic                q_full,
  output logic                push,
  output zrwc_pkg::job_t      push_job
);

  typedef enum logic [1:0] {PH_WORD, PH_COUNT, PH_END_WORD, PH_END_COUNT} phase_t;

  logic [zrwc_pkg::LEN_W-1:0] pos_r, pos_nxt;
  logic [zrwc_pkg::LEN_W-1:0] zrl_r, zrl_nxt;
  phase_t                     phase_r, phase_nxt;
  logic                       emb_r, emb_nxt;

  logic                       accept;
  logic                       w_nz;
  logic [15:0]                low;
  logic [zrwc_pkg::LEN_W-1:0] pos_inc;
  logic                       at_end;
  logic [zrwc_pkg::LEN_W-1:0] zrl1;
  logic [zrwc_pkg::EXTRA_W-1:0] extra;
  logic [zrwc_pkg::LEN_W-1:0] rem;
  logic                       overrun;
  logic [zrwc_pkg::LEN_W-1:0] pos_after;
  zrwc_pkg::job_t             job;
  logic                       job_ok;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  assign w_nz    = |in_ch.data;
  assign low     = in_ch.data[15:0];
  assign pos_inc = pos_r + zrwc_pkg::LEN_W'(1);
  assign at_end  = pos_inc >= cfg.eff_len;
  assign zrl1    = w_nz ? '0 : zrl_r + zrwc_pkg::LEN_W'(1);

  // Count token: values of one or less (negative too) add no zeros
  assign extra     = (!low[15] && low > 16'd1) ?
                     low[zrwc_pkg::EXTRA_W-1:0] - zrwc_pkg::EXTRA_W'(1) : '0;
  assign rem       = cfg.eff_len - zrwc_pkg::LEN_W'(1) - pos_r;
  assign overrun   = extra > {{(zrwc_pkg::EXTRA_W - zrwc_pkg::LEN_W){1'b0}}, rem};
  assign pos_after = pos_inc + extra[zrwc_pkg::LEN_W-1:0];

  always_comb begin
    pos_nxt   = pos_r;
    zrl_nxt   = zrl_r;
    phase_nxt = phase_r;
    emb_nxt   = emb_r;
    job       = '0;
    job_ok    = 1'b0;
    job.value = in_ch.data;
    if (accept) begin
      if (cfg.direction == zrwc_pkg::DIR_ENCODE) begin
        job.is_run    = 1'b0;
        job.pre_count = zrl_r;
        job.run_count = zrl1;
        job.mask[zrwc_pkg::SLOT_PRE_COUNT] = w_nz && (zrl_r != '0);
        job.mask[zrwc_pkg::SLOT_WORD]      = w_nz || (zrl_r == '0);
        job.mask[zrwc_pkg::SLOT_RUN_COUNT] = at_end && (zrl1 != '0);
        job.mask[zrwc_pkg::SLOT_END_WORD]  = at_end;
        job.mask[zrwc_pkg::SLOT_END_COUNT] = at_end;
        job_ok = |job.mask;
        if (at_end) begin
          pos_nxt = '0;
          zrl_nxt = '0;
        end else begin
          pos_nxt = pos_inc;
          zrl_nxt = zrl1;
        end
      end else begin
        job.is_run = 1'b1;
        job.status = zrwc_pkg::ST_OK;
        case (phase_r)
          PH_WORD: begin
            if (w_nz) begin
              job_ok    = 1'b1;
              job.start = pos_r[zrwc_pkg::IDX_W-1:0];
              job.len   = zrwc_pkg::LEN_W'(1);
              pos_nxt   = pos_inc;
              phase_nxt = at_end ? PH_END_WORD : PH_WORD;
            end else begin
              phase_nxt = PH_COUNT;
            end
          end
          PH_COUNT: begin
            job_ok    = 1'b1;
            job.value = '0;
            job.start = pos_r[zrwc_pkg::IDX_W-1:0];
            if (overrun) begin
              // Zeros that fit are emitted, the last flags the overrun
              job.len    = rem + zrwc_pkg::LEN_W'(1);
              job.done   = 1'b1;
              job.status = zrwc_pkg::ST_OVERRUN;
              pos_nxt    = '0;
              zrl_nxt    = '0;
              phase_nxt  = PH_WORD;
              emb_nxt    = 1'b0;
            end else begin
              job.len   = extra[zrwc_pkg::LEN_W-1:0] + zrwc_pkg::LEN_W'(1);
              pos_nxt   = pos_after;
              phase_nxt = (pos_after >= cfg.eff_len) ? PH_END_WORD : PH_WORD;
            end
          end
          PH_END_WORD: begin
            emb_nxt   = w_nz;
            phase_nxt = PH_END_COUNT;
          end
          PH_END_COUNT: begin
            job_ok     = 1'b1;
            job.value  = '0;
            job.start  = '0;
            job.len    = zrwc_pkg::LEN_W'(1);
            job.done   = 1'b1;
            job.status = (emb_r || (low != 16'd0)) ? zrwc_pkg::ST_BAD_END : zrwc_pkg::ST_OK;
            pos_nxt    = '0;
            zrl_nxt    = '0;
            phase_nxt  = PH_WORD;
            emb_nxt    = 1'b0;
          end
          default: begin
            phase_nxt = PH_WORD;
          end
        endcase
      end
    end
    if (cfg.clear) begin
      pos_nxt   = '0;
      zrl_nxt   = '0;
      phase_nxt = PH_WORD;
      emb_nxt   = 1'b0;
    end
  end

  assign push     = accept && job_ok;
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      zrl_r   <= '0;
      phase_r <= PH_WORD;
      emb_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      zrl_r   <= zrl_nxt;
      phase_r <= phase_nxt;
      emb_r   <= emb_nxt;
    end
  end

  // Decode sits at the vector length while it waits for the end marker
  `ZRWC_ASSERT_ALWAYS(a_pos_in_vector, pos_r <= cfg.eff_len, "position beyond vector length")

endmodule

FILE: src/zrwc_queue.sv
// Job queue between the front and back ends.
// Depends on zrwc_pkg and the assertion header.
`timescale 1ns / 1ps
`include "zero_run_word_codec_assert.svh"

module zrwc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  zrwc_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output zrwc_pkg::job_t  head_job
);

  zrwc_pkg::job_t                mem_r [zrwc_pkg::QDEPTH];
  logic [zrwc_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [zrwc_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [zrwc_pkg::QCNT_W-1:0]   count_r, count_nxt;

  assign full       = count_r == zrwc_pkg::QCNT_W'(zrwc_pkg::QDEPTH);
  assign head_valid = count_r != '0;
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + zrwc_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + zrwc_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + zrwc_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - zrwc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `ZRWC_ASSERT_ALWAYS(a_queue_bound, count_r <= zrwc_pkg::QCNT_W'(zrwc_pkg::QDEPTH), "queue count overflow")

endmodule

FILE: src/zrwc_back.sv
// Back end: expands jobs into result words into an output register.
// Depends on zrwc_pkg, zrwc_if and the assertion header.
`timescale 1ns / 1ps
`include "zero_run_word_codec_assert.svh"

module zrwc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  zrwc_pkg::job_t  head_job,
  output logic            pop,
  zrwc_out_if.source      out_ch
);

  logic [zrwc_pkg::IDX_W-1:0]     k_r, k_nxt;
  logic [zrwc_pkg::SLOTS-1:0]     sent_r, sent_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [zrwc_pkg::WORD_BITS-1:0] value_r;
  logic                           is_count_r;
  logic [zrwc_pkg::IDX_W-1:0]     word_index_r;
  logic                           done_res_r;
  logic [zrwc_pkg::STATUS_W-1:0]  status_r;
  logic                           last_r;

  logic                           produce;
  logic [zrwc_pkg::SLOTS-1:0]     remaining, pick, rest;
  logic                           run_last;
  logic                           job_last;
  logic [zrwc_pkg::WORD_BITS-1:0] res_value;
  logic                           res_is_count;
  logic [zrwc_pkg::IDX_W-1:0]     res_index;
  logic                           res_done;
  logic [zrwc_pkg::STATUS_W-1:0]  res_status;

  assign produce   = head_valid && (!out_valid_r || out_ch.ready);
  assign remaining = head_job.mask & ~sent_r;
  assign pick      = remaining & (~remaining + zrwc_pkg::SLOTS'(1));
  assign rest      = remaining & ~pick;
  assign run_last  = {1'b0, k_r} == (head_job.len - zrwc_pkg::LEN_W'(1));
  assign job_last  = head_job.is_run ? run_last : (rest == '0);
  assign pop       = produce && job_last;

  always_comb begin
    res_value    = '0;
    res_is_count = 1'b0;
    res_index    = '0;
    res_done     = 1'b0;
    res_status   = zrwc_pkg::ST_OK;
    if (head_job.is_run) begin
      res_value  = head_job.value;
      res_index  = head_job.start + k_r;
      res_done   = run_last && head_job.done;
      res_status = run_last ? head_job.status : zrwc_pkg::ST_OK;
    end else if (pick[zrwc_pkg::SLOT_PRE_COUNT]) begin
      res_value    = {{(zrwc_pkg::WORD_BITS - zrwc_pkg::LEN_W){1'b0}}, head_job.pre_count};
      res_is_count = 1'b1;
    end else if (pick[zrwc_pkg::SLOT_WORD]) begin
      res_value = head_job.value;
    end else if (pick[zrwc_pkg::SLOT_RUN_COUNT]) begin
      res_value    = {{(zrwc_pkg::WORD_BITS - zrwc_pkg::LEN_W){1'b0}}, head_job.run_count};
      res_is_count = 1'b1;
    end else if (pick[zrwc_pkg::SLOT_END_COUNT]) begin
      // end marker count closes the vector; the marker word slot is all zero
      res_is_count = 1'b1;
      res_done     = 1'b1;
    end
  end

  always_comb begin
    k_nxt         = k_r;
    sent_nxt      = sent_r;
    out_valid_nxt = out_valid_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
      if (job_last) begin
        k_nxt    = '0;
        sent_nxt = '0;
      end else begin
        k_nxt    = k_r + zrwc_pkg::IDX_W'(1);
        sent_nxt = sent_r | pick;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      value_r      <= res_value;
      is_count_r   <= res_is_count;
      word_index_r <= res_index;
      done_res_r   <= res_done;
      status_r     <= res_status;
      last_r       <= job_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = value_r;
  assign out_ch.is_count   = is_count_r;
  assign out_ch.word_index = word_index_r;
  assign out_ch.done_res   = done_res_r;
  assign out_ch.status     = status_r;
  assign out_ch.last       = last_r;

  `ZRWC_ASSERT_IMPL(a_done_is_last, out_valid_r && done_res_r, last_r, "vector end not last word")
  `ZRWC_ASSERT_IMPL(a_error_ends, out_valid_r && (status_r != zrwc_pkg::ST_OK), done_res_r, "error status without vector end")

endmodule

FILE: src/zero_run_word_codec.sv
// Zero-run word codec: top level, configuration registers and APB port.
// Depends on zrwc_pkg, zrwc_if, zrwc_front, zrwc_queue and zrwc_back.
// Usage:
//  in_ch   : one word per handshake (valid/ready). Encode: a vector word.
//            Decode: a token, word or count (count in the low 16 bits, signed).
//  out_ch  : result words, registered; last marks the final result of an input.
//  cfg_*   : APB write/read. 0x0 direction (0 encode, 1 decode),
//            0x4 vector_words (0 acts as 1, above 64 as 64). Any write
//            abandons the vector in progress. Write only while idle.
//  Path    : a taken input goes into the job queue, then the output register.
//  Rate    : one input per cycle while each yields one result and out_ch.ready
//            stays high. An input yielding k results holds the back end until
//            all k are sent (encode up to 4, a decode count up to 64); a
//            four-deep job queue lets the front keep taking words meanwhile. Inputs
//            yielding nothing (decode zero word, end marker word) push no job.
//  Stall   : out_ch.ready low holds the output register; the queue fills
//            and in_ch.ready drops when it is full.
//  Reset   : rst_n synchronous, active low: encode, vector of one word,
//            queue empty, no result pending.
`timescale 1ns / 1ps

module zero_run_word_codec (
  input  logic                                clk,
  input  logic                                rst_n,
  zrwc_in_if.sink                             in_ch,
  zrwc_out_if.source                          out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [zrwc_pkg::REG_ADDR_W-1:0]     cfg_paddr,
  input  logic [zrwc_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  output logic [zrwc_pkg::APB_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  logic                          direction_r;
  logic [zrwc_pkg::LEN_W-1:0]    vector_words_r;
  logic                          cfg_write;
  logic                          reg_sel;
  logic [zrwc_pkg::LEN_W-1:0]    eff_len;
  zrwc_pkg::cfg_t                cfg;

  logic                          push;
  zrwc_pkg::job_t                push_job;
  logic                          q_full;
  logic                          pop;
  logic                          head_valid;
  zrwc_pkg::job_t                head_job;

  // Register select is the word address bit; every write hits a register
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[zrwc_pkg::REG_ADDR_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r    <= zrwc_pkg::DIR_ENCODE;
      vector_words_r <= zrwc_pkg::LEN_W'(1);
    end else if (cfg_write) begin
      if (reg_sel == zrwc_pkg::REG_DIRECTION) begin
        direction_r <= cfg_pwdata[0];
      end else begin
        vector_words_r <= cfg_pwdata[zrwc_pkg::LEN_W-1:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_sel == zrwc_pkg::REG_VECTOR_WORDS) begin
      cfg_prdata[zrwc_pkg::LEN_W-1:0] = vector_words_r;
    end else begin
      cfg_prdata[0] = direction_r;
    end
  end

  // Clamp the vector length into 1..MAX_WORDS
  always_comb begin
    if (vector_words_r == '0) begin
      eff_len = zrwc_pkg::LEN_W'(1);
    end else if (vector_words_r > zrwc_pkg::LEN_W'(zrwc_pkg::MAX_WORDS)) begin
      eff_len = zrwc_pkg::LEN_W'(zrwc_pkg::MAX_WORDS);
    end else begin
      eff_len = vector_words_r;
    end
  end

  // The write edge also clears the vector state in the front end
  assign cfg.direction = direction_r;
  assign cfg.eff_len   = eff_len;
  assign cfg.clear     = cfg_write;

  zrwc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  zrwc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  zrwc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

FILE: dv/zero_run_word_codec_tb.sv
// Testbench for zero_run_word_codec: directed and random word streams in both directions.
// A predictor checks every result word. Needs zrwc_pkg, zrwc_if and the codec RTL.
`timescale 1ns / 1ps

module zero_run_word_codec_tb;

  localparam int CYCLE_LIMIT   = 500_000;
  localparam int SETTLE_CYCLES = 8;    // covers the job queue and output register with margin
  localparam int PHASE_WORDS   = 10;   // minimum input words per traffic phase of the random part

  // Decode progress through one vector.
  typedef enum logic [1:0] {
    EXPECT_WORD,
    EXPECT_COUNT,
    EXPECT_END_WORD,
    EXPECT_END_COUNT
  } dec_phase_t;

  typedef struct packed {
    logic [zrwc_pkg::WORD_BITS-1:0] value;
    logic                           is_count;
    logic [zrwc_pkg::IDX_W-1:0]     word_index;
    logic                           done_res;
    logic [zrwc_pkg::STATUS_W-1:0]  status;
    logic                           last;
  } out_word_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [zrwc_pkg::REG_ADDR_W-1:0] cfg_paddr;
  logic [zrwc_pkg::APB_DATA_W-1:0] cfg_pwdata;
  logic [zrwc_pkg::APB_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  zrwc_in_if  in_ch ();
  zrwc_out_if out_ch ();

  zero_run_word_codec uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: its own copy of the registers and of the vector progress.
  logic        pred_direction;
  logic [6:0]  pred_vector_words;
  int          pred_position;
  int          pred_run;
  dec_phase_t  pred_phase;
  bit          pred_end_bad;

  out_word_t   expected_out_words[$];   // results still to arrive, oldest first
  out_word_t   staged_words[$];         // results of the input word being predicted

  int failures      = 0;
  int cycle_count   = 0;
  int items_sent    = 0;
  int hold_cycles   = 0;                // long receiver hold-off, counted down below
  int send_idle_pct = 0;
  int sink_stall_pct = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Register value 0 behaves as a single word, anything above the maximum as the maximum.
  function automatic int eff_words(logic [6:0] vw);
    if (vw == 0) return 1;
    if (vw > zrwc_pkg::MAX_WORDS) return zrwc_pkg::MAX_WORDS;
    return int'(vw);
  endfunction

  function automatic void reset_vector_state();
    pred_position = 0;
    pred_run      = 0;
    pred_phase    = EXPECT_WORD;
    pred_end_bad  = 1'b0;
  endfunction

  function automatic void emit_word(logic [zrwc_pkg::WORD_BITS-1:0] value, logic is_count,
                                    int word_idx, logic done,
                                    logic [zrwc_pkg::STATUS_W-1:0] status);
    out_word_t w;
    w.value      = value;
    w.is_count   = is_count;
    w.word_index = zrwc_pkg::IDX_W'(word_idx);
    w.done_res   = done;
    w.status     = status;
    w.last       = 1'b0;
    staged_words.push_back(w);
  endfunction

  function automatic void encode_word(logic [zrwc_pkg::WORD_BITS-1:0] w);
    int n;
    n = eff_words(pred_vector_words);
    if (w != 0) begin
      // a nonzero word closes any zero run: its length goes out first
      if (pred_run > 0) begin
        emit_word(zrwc_pkg::WORD_BITS'(pred_run & 'hFFFF), 1'b1, 0, 1'b0, zrwc_pkg::ST_OK);
        pred_run = 0;
      end
      emit_word(w, 1'b0, 0, 1'b0, zrwc_pkg::ST_OK);
    end else begin
      // only the first zero of a run is sent as a word
      if (pred_run == 0) emit_word('0, 1'b0, 0, 1'b0, zrwc_pkg::ST_OK);
      pred_run++;
    end
    pred_position++;
    if (pred_position >= n) begin
      // flush a trailing run, then the end marker: word 0, count 0
      if (pred_run > 0) begin
        emit_word(zrwc_pkg::WORD_BITS'(pred_run & 'hFFFF), 1'b1, 0, 1'b0, zrwc_pkg::ST_OK);
      end
      emit_word('0, 1'b0, 0, 1'b0, zrwc_pkg::ST_OK);
      emit_word('0, 1'b1, 0, 1'b1, zrwc_pkg::ST_OK);
      reset_vector_state();
    end
  endfunction

  function automatic void decode_token(logic [zrwc_pkg::WORD_BITS-1:0] d);
    int              n;
    int              extra;
    logic signed [15:0] run_len;
    out_word_t       tail;
    n = eff_words(pred_vector_words);
    run_len = d[15:0];
    case (pred_phase)
      EXPECT_WORD: begin
        if (d != 0) begin
          emit_word(d, 1'b0, pred_position, 1'b0, zrwc_pkg::ST_OK);
          pred_position++;
          pred_phase = (pred_position >= n) ? EXPECT_END_WORD : EXPECT_WORD;
        end else begin
          // zero word waits for its count
          pred_phase = EXPECT_COUNT;
        end
      end
      EXPECT_COUNT: begin
        extra = (run_len > 1) ? int'(run_len) - 1 : 0;
        emit_word('0, 1'b0, pred_position, 1'b0, zrwc_pkg::ST_OK);
        for (int e = 0; e < extra; e++) begin
          if (pred_position + 1 >= n) begin
            // run overruns the vector: the last zero that fits ends it with an error
            tail = staged_words.pop_back();
            tail.done_res = 1'b1;
            tail.status   = zrwc_pkg::ST_OVERRUN;
            staged_words.push_back(tail);
            reset_vector_state();
            return;
          end
          pred_position++;
          emit_word('0, 1'b0, pred_position, 1'b0, zrwc_pkg::ST_OK);
        end
        pred_position++;
        pred_phase = (pred_position >= n) ? EXPECT_END_WORD : EXPECT_WORD;
      end
      EXPECT_END_WORD: begin
        pred_end_bad = (d != 0);
        pred_phase   = EXPECT_END_COUNT;
      end
      default: begin
        if (d[15:0] != 0) pred_end_bad = 1'b1;
        emit_word('0, 1'b0, 0, 1'b1, pred_end_bad ? zrwc_pkg::ST_BAD_END : zrwc_pkg::ST_OK);
        reset_vector_state();
      end
    endcase
  endfunction

  // Works out every result of one accepted input word and queues them.
  function automatic void predict_results(logic [zrwc_pkg::WORD_BITS-1:0] d);
    out_word_t tail;
    staged_words.delete();
    if (pred_direction == zrwc_pkg::DIR_ENCODE) encode_word(d);
    else decode_token(d);
    if (staged_words.size() > 0) begin
      tail = staged_words.pop_back();
      tail.last = 1'b1;
      staged_words.push_back(tail);
    end
    foreach (staged_words[i]) expected_out_words.push_back(staged_words[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_out_words.size() == 0) begin
        $error("result word 0x%0h with nothing expected", out_ch.value);
        failures++;
      end else begin
        want = expected_out_words.pop_front();
        check_field("value", want.value, out_ch.value);
        check_field("is_count", 32'(want.is_count), 32'(out_ch.is_count));
        check_field("word_index", 32'(want.word_index), 32'(out_ch.word_index));
        check_field("done_res", 32'(want.done_res), 32'(out_ch.done_res));
        check_field("status", 32'(want.status), 32'(out_ch.status));
        check_field("last", 32'(want.last), 32'(out_ch.last));
      end
    end
  end

  // Receiver: a long hold-off when asked for, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles   <= hold_cycles - 1;
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready  <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (all called at a falling edge, and return at one)
  // ---------------------------------------------------------------------------

  // Offers one word; valid stays high on return so back-to-back words need no gap.
  task automatic send_word(input logic [zrwc_pkg::WORD_BITS-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= d;
    do @(posedge clk); while (!in_ch.ready);
    predict_results(d);
    items_sent++;
    @(negedge clk);
  endtask

  // Stops sending and lets every outstanding result, and any word still held inside, drain.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_out_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_transfer(input logic wr, input logic reg_idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Register write while idle, then read back. Any write drops the vector in progress.
  task automatic cfg_write(input logic reg_idx, input logic [31:0] val);
    logic [31:0] readback;
    wait_idle();
    apb_transfer(1'b1, reg_idx, val, readback);
    if (reg_idx == zrwc_pkg::REG_DIRECTION) pred_direction = val[0];
    else pred_vector_words = val[6:0];
    reset_vector_state();
    apb_transfer(1'b0, reg_idx, '0, readback);
    check_field("register readback", (reg_idx == zrwc_pkg::REG_DIRECTION) ?
                {31'b0, pred_direction} : {25'b0, pred_vector_words}, readback);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [zrwc_pkg::WORD_BITS-1:0] rand_word();
    logic [zrwc_pkg::WORD_BITS-1:0] w;
    case ($urandom_range(7))
      0, 1:    w = 32'h1 << $urandom_range(31);
      2:       w = 32'hFFFF_FFFF;
      3:       w = ~(32'h1 << $urandom_range(31));
      default: w = $urandom;
    endcase
    if (w == 0) w = 32'h8000_0000;
    return w;
  endfunction

  // Anything a decoder might be fed: zeros, small or negative counts, plain words.
  function automatic logic [zrwc_pkg::WORD_BITS-1:0] noise_token();
    logic [zrwc_pkg::WORD_BITS-1:0] r;
    r = $urandom;
    case ($urandom_range(3))
      0:       return '0;
      1:       return {r[31:16], 16'($urandom_range(80))};
      2:       return r;
      default: return rand_word();
    endcase
  endfunction

  task automatic send_encode_vector(input int n);
    repeat (n) send_word($urandom_range(1) ? '0 : rand_word());
  endtask

  // Well-formed token stream of one vector: words, zero runs as word 0 plus count, end marker.
  task automatic send_decode_vector(input int n);
    int pos;
    int run;
    pos = 0;
    while (pos < n) begin
      if ($urandom_range(1)) begin
        send_word(rand_word());
        pos++;
      end else begin
        run = $urandom_range(1, n - pos);
        send_word('0);
        send_word({16'($urandom_range(1) ? $urandom : 0), 16'(run)});
        pos += run;
      end
    end
    send_word('0);
    send_word({16'($urandom_range(1) ? $urandom : 0), 16'h0000});
  endtask

  // One random setting followed by a few vectors; sometimes noise, sometimes a cut-off vector.
  task automatic random_segment();
    logic       dir;
    logic [6:0] vw;
    int         pick;
    int         n;
    dir  = $urandom_range(1);
    pick = $urandom_range(99);
    if (pick < 75)      vw = 7'($urandom_range(1, 8));
    else if (pick < 82) vw = 7'd0;
    else if (pick < 89) vw = 7'd64;
    else if (pick < 94) vw = 7'd127;
    else                vw = 7'($urandom_range(9, 127));
    cfg_write(zrwc_pkg::REG_DIRECTION, 32'(dir));
    cfg_write(zrwc_pkg::REG_VECTOR_WORDS, 32'(vw));
    n = eff_words(vw);
    repeat ((n > 8) ? 1 : $urandom_range(1, 3)) begin
      if (dir == zrwc_pkg::DIR_ENCODE) begin
        send_encode_vector(n);
      end else begin
        if ($urandom_range(99) < 20) repeat ($urandom_range(1, 4)) send_word(noise_token());
        send_decode_vector(n);
      end
    end
    // vector left unfinished: the next register write has to abandon it
    if ($urandom_range(3) == 0) begin
      if (dir == zrwc_pkg::DIR_DECODE) send_word($urandom_range(1) ? '0 : rand_word());
      else if (n > 1) send_encode_vector($urandom_range(1, n - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_encode_edges();
    cfg_write(zrwc_pkg::REG_DIRECTION, 32'(zrwc_pkg::DIR_ENCODE));
    cfg_write(zrwc_pkg::REG_VECTOR_WORDS, 0);          // acts as a one-word vector
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);                // trailing run flushed before the end marker
    cfg_write(zrwc_pkg::REG_VECTOR_WORDS, 4);
    send_word(32'h0000_0001);
    send_word(32'h0000_0000);
    send_word(32'h0000_0000);
    send_word(32'h8000_0000);                // closes a run of two
  endtask

  task automatic test_decode_tokens();
    cfg_write(zrwc_pkg::REG_DIRECTION, 32'(zrwc_pkg::DIR_DECODE));
    cfg_write(zrwc_pkg::REG_VECTOR_WORDS, 7);
    send_word(32'hFFFF_FFFF);
    send_word('0); send_word(32'h0000_0003);     // run of three
    send_word('0); send_word(32'h0000_FFFF);     // negative count: just the zero word
    send_word('0); send_word(32'hFFFF_0000);     // count 0, upper bits ignored
    send_word('0); send_word(32'h0000_0001);     // count 1 fills the last word
    send_word('0); send_word('0);                // good end marker
  endtask

  task automatic test_decode_errors();
    cfg_write(zrwc_pkg::REG_VECTOR_WORDS, 127);  // clamps to the maximum
    send_word('0); send_word(32'h0000_7FFF);     // overrun: maximum burst of zeros
    cfg_write(zrwc_pkg::REG_VECTOR_WORDS, 1);
    send_word(32'h0000_000A);
    send_word(32'h0000_0005); send_word('0);     // end marker word not zero
    send_word(32'h0000_000B);
    send_word('0); send_word(32'hFFFF_0007);     // end marker count not zero
  endtask

  task automatic test_register_write_abandons();
    cfg_write(zrwc_pkg::REG_VECTOR_WORDS, 4);
    send_word(32'h0000_0005);
    send_word('0);                               // zero word held, no result yet
    cfg_write(zrwc_pkg::REG_VECTOR_WORDS, 2);    // must drop it
    send_word(32'h0000_0006);
    send_word('0); send_word(32'h0000_0001);
    send_word('0); send_word('0);
  endtask

  // Receiver holds off while words keep coming, so the block fills and stalls its input;
  // then the sender waits for every result before going on.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    cfg_write(zrwc_pkg::REG_DIRECTION, 32'(zrwc_pkg::DIR_ENCODE));
    cfg_write(zrwc_pkg::REG_VECTOR_WORDS, 3);
    hold_cycles = 300;
    repeat (16) send_word(($urandom_range(2) == 0) ? '0 : rand_word());
    wait_idle();
    repeat (4) send_word(($urandom_range(2) == 0) ? '0 : rand_word());
  endtask

  task automatic test_random_traffic();
    int idle_pcts[4]  = '{0, 63, 0, 34};
    int stall_pcts[4] = '{0, 0, 63, 34};
    int start;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pcts[p];
      sink_stall_pct = stall_pcts[p];
      start = items_sent;
      while (items_sent - start < PHASE_WORDS) random_segment();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    pred_direction    = zrwc_pkg::DIR_ENCODE;
    pred_vector_words = 7'd1;
    reset_vector_state();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_encode_edges();
    test_decode_tokens();
    test_decode_errors();
    test_register_write_abandons();
    test_backpressure();
    test_random_traffic();

    send_idle_pct  = 0;
    sink_stall_pct = 0;
    wait_idle();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/zrwc_pkg.sv
src/zrwc_if.sv
src/zrwc_front.sv
src/zrwc_queue.sv
src/zrwc_back.sv
src/zero_run_word_codec.sv
dv/zero_run_word_codec_tb.sv
